// ===== rtl/core/kvp_pkg.sv =====
// ----------------------------------------------------------------------------
// kvp_pkg
// shared types, limits and helpers for the key/value request line parser
// ----------------------------------------------------------------------------
package kvp_pkg;

    localparam int MAX_LINE    = 1024;
    localparam int KEY_BYTES   = 256;
    localparam int VALUE_BYTES = 1024;

    localparam int LINE_CW = $clog2(MAX_LINE + 1);
    localparam int KEY_CW  = $clog2(KEY_BYTES + 1);

    localparam logic [23:0] WORD_GET = 24'h474554;
    localparam logic [23:0] WORD_DEL = 24'h44454C;
    localparam logic [23:0] WORD_SET = 24'h534554;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_CMD,
        PH_GAP1,
        PH_KEY,
        PH_TAIL,
        PH_GAP2,
        PH_VALUE,
        PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        CMD_GET,
        CMD_DEL,
        CMD_SET,
        CMD_BAD
    } t_cmd;

    typedef enum logic [1:0] {
        ROLE_NONE,
        ROLE_KEY,
        ROLE_VALUE
    } t_role;

    typedef struct packed {
        logic [7:0] echo_byte;
        t_role      role;
        logic [9:0] field_pos;
        logic       done_res;
        logic       status;
        logic [1:0] command;
        logic [7:0] key_length;
        logic [9:0] value_length;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_cmd cmd_code(input logic [23:0] chars, input logic [2:0] count);
        t_cmd code;
        code = CMD_BAD;
        if (count == 3'd3) begin
            if (chars == WORD_GET) begin
                code = CMD_GET;
            end else if (chars == WORD_DEL) begin
                code = CMD_DEL;
            end else if (chars == WORD_SET) begin
                code = CMD_SET;
            end
        end
        return code;
    endfunction

    // clamp a count to a 10 bit field
    function automatic logic [9:0] sat10(input logic [31:0] v);
        return (v < 32'd1023) ? v[9:0] : 10'd1023;
    endfunction

    function automatic logic [7:0] sat8(input logic [31:0] v);
        return (v < 32'd255) ? v[7:0] : 8'd255;
    endfunction

endpackage

// ===== rtl/core/kvp_parse.sv =====
// ----------------------------------------------------------------------------
// kvp_parse
// parser state and per-byte decode: role tag, field position and verdict
// ----------------------------------------------------------------------------
module kvp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output kvp_pkg::t_result o_result
);
    import kvp_pkg::*;

    t_phase               r_phase,  n_phase;
    logic [23:0]          r_chars,  n_chars;
    logic [2:0]           r_ccount, n_ccount;
    logic [LINE_CW-1:0]   r_line,   n_line;
    logic [KEY_CW-1:0]    r_key,    n_key;
    logic [LINE_CW-1:0]   r_value,  n_value;
    logic [LINE_CW-1:0]   r_crlf,   n_crlf;
    logic                 r_term,   n_term;

    logic                 ws;
    t_cmd                 cur_code;
    t_cmd                 fin_code;
    logic [LINE_CW-1:0]   vl;
    logic                 ok;
    t_role                role;
    logic [9:0]           pos;

    assign ws       = is_ws(i_byte);
    assign cur_code = cmd_code(r_chars, r_ccount);

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_chars  = r_chars;
        n_ccount = r_ccount;
        n_line   = r_line;
        n_key    = r_key;
        n_value  = r_value;
        n_crlf   = r_crlf;
        n_term   = r_term;
        role     = ROLE_NONE;
        pos      = 10'd0;
        if (!r_term) begin
            if (i_byte == CH_NUL) begin
                n_term = 1'b1;
            end else begin
                n_line = (r_line < LINE_CW'(MAX_LINE)) ? r_line + 1'b1 : LINE_CW'(MAX_LINE);
                case (r_phase)
                    PH_LEAD: begin
                        if (!ws) begin
                            n_chars  = {r_chars[15:0], i_byte};
                            n_ccount = (r_ccount < 3'd4) ? r_ccount + 3'd1 : 3'd4;
                            n_phase  = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        if (!ws) begin
                            n_chars  = {r_chars[15:0], i_byte};
                            n_ccount = (r_ccount < 3'd4) ? r_ccount + 3'd1 : 3'd4;
                        end else begin
                            n_phase = (cur_code == CMD_BAD) ? PH_ERR : PH_GAP1;
                        end
                    end
                    PH_GAP1: begin
                        if (!ws) begin
                            role    = ROLE_KEY;
                            n_key   = KEY_CW'(1);
                            n_phase = PH_KEY;
                        end
                    end
                    PH_KEY: begin
                        if (!ws) begin
                            role  = ROLE_KEY;
                            pos   = sat10(32'(r_key));
                            n_key = (r_key < KEY_CW'(KEY_BYTES)) ? r_key + 1'b1
                                                                 : KEY_CW'(KEY_BYTES);
                        end else begin
                            n_phase = (cur_code == CMD_SET) ? PH_GAP2 : PH_TAIL;
                        end
                    end
                    PH_TAIL: begin
                        if (!ws) begin
                            n_phase = PH_ERR;
                        end
                    end
                    PH_GAP2: begin
                        if (!ws) begin
                            role    = ROLE_VALUE;
                            n_value = LINE_CW'(1);
                            n_crlf  = '0;
                            n_phase = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        role    = ROLE_VALUE;
                        pos     = sat10(32'(r_value));
                        n_value = (r_value < LINE_CW'(MAX_LINE)) ? r_value + 1'b1
                                                                 : LINE_CW'(MAX_LINE);
                        if (i_byte == CH_LF || i_byte == CH_CR) begin
                            n_crlf = (r_crlf < LINE_CW'(MAX_LINE)) ? r_crlf + 1'b1
                                                                   : LINE_CW'(MAX_LINE);
                        end else begin
                            n_crlf = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_ERR;
                    end
                endcase
            end
        end
    end

    // verdict on the updated state
    always_comb begin
        fin_code = cmd_code(n_chars, n_ccount);
        vl       = (n_value >= n_crlf) ? n_value - n_crlf : '0;
        ok       = 1'b0;
        if (n_line < LINE_CW'(MAX_LINE)) begin
            if ((n_phase == PH_KEY || n_phase == PH_TAIL) &&
                (fin_code == CMD_GET || fin_code == CMD_DEL)) begin
                ok = (32'(n_key) < 32'(KEY_BYTES));
            end else if (n_phase == PH_VALUE && fin_code == CMD_SET) begin
                ok = (32'(n_key) < 32'(KEY_BYTES)) && (32'(vl) < 32'(VALUE_BYTES));
            end
        end
    end

    // result fields
    always_comb begin
        o_result              = '0;
        o_result.echo_byte    = i_byte;
        o_result.role         = role;
        o_result.field_pos    = pos;
        o_result.done_res     = i_last;
        if (i_last) begin
            if (ok) begin
                o_result.command    = fin_code;
                o_result.key_length = sat8(32'(n_key));
                if (fin_code == CMD_SET) begin
                    o_result.value_length = sat10(32'(vl));
                end
            end else begin
                o_result.status = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_chars  <= '0;
            r_ccount <= '0;
            r_line   <= '0;
            r_key    <= '0;
            r_value  <= '0;
            r_crlf   <= '0;
            r_term   <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_phase  <= PH_LEAD;
                r_chars  <= '0;
                r_ccount <= '0;
                r_line   <= '0;
                r_key    <= '0;
                r_value  <= '0;
                r_crlf   <= '0;
                r_term   <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_chars  <= n_chars;
                r_ccount <= n_ccount;
                r_line   <= n_line;
                r_key    <= n_key;
                r_value  <= n_value;
                r_crlf   <= n_crlf;
                r_term   <= n_term;
            end
        end
    end

endmodule

// ===== rtl/core/kv_request_line_parser.sv =====
// the output register holds each accepted byte's result from the cycle after it
// throughput: one byte per cycle unless the output stalls; the output register refills
// as it drains, a rate set by the single result register behind the per-byte decode
// reset (synchronous, active low) returns the parser to the leading whitespace phase
// and empties the output register; each line end also returns the parser to that phase
// ----------------------------------------------------------------------------
// kv_request_line_parser
// byte stream parser for GET/DEL/SET request lines with role tagging and verdict
// ----------------------------------------------------------------------------
module kv_request_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte
    input  logic        i_s_tlast,   // line_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // echo_byte[7:0], field_pos[17:8], status[18], command[20:19],
    // key_length[28:21], value_length[38:29], zero pad[39]
    output logic [39:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // role
    output logic        o_m_tlast    // done_res
);
    import kvp_pkg::*;

    logic    accept;
    t_result step_res;
    t_result r_res;
    logic    r_valid;

    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    kvp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_res.value_length, r_res.key_length, r_res.command,
                         r_res.status, r_res.field_pos, r_res.echo_byte};
    assign o_m_tuser  = r_res.role;
    assign o_m_tlast  = r_res.done_res;

`ifndef NO_ASSERTIONS
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[18] |-> o_m_tlast)
        else $error("error status on a result that is not a line end");

    a_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (!o_m_tlast || o_m_tdata[18]) |-> o_m_tdata[38:19] == 20'd0)
        else $error("verdict fields set without an accepted line end");

    a_pos_no_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ROLE_NONE |-> o_m_tdata[17:8] == 10'd0)
        else $error("field position set on an untagged byte");

    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid && o_m_tdata[7:0] == $past(i_s_tdata))
        else $error("echoed byte differs from accepted byte");
`endif

endmodule

// ===== tb/kvp_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// kvp_scoreboard_pkg
// request line predictor and result scoreboard for the key/value line parser
// ----------------------------------------------------------------------------
package kvp_scoreboard_pkg;

    import kvp_pkg::*;

    function automatic bit space_char(input logic [7:0] c);
        return c inside {CH_SP, [CH_TAB:CH_CR]};
    endfunction

    class line_scoreboard;

        t_phase      ph;
        logic [23:0] word;
        logic [2:0]  word_len;
        logic [10:0] line_len;
        logic [8:0]  key_len;
        logic [10:0] val_len;
        logic [10:0] crlf_len;
        bit          stopped;

        t_result     expected_q[$];
        int          mismatches;

        function new();
            clear_line();
            mismatches = 0;
        endfunction

        function void clear_line();
            ph       = PH_LEAD;
            word     = '0;
            word_len = '0;
            line_len = '0;
            key_len  = '0;
            val_len  = '0;
            crlf_len = '0;
            stopped  = 1'b0;
        endfunction

        function t_cmd word_cmd();
            if (word_len != 3'd3) begin
                return CMD_BAD;
            end
            case (word)
                WORD_GET: return CMD_GET;
                WORD_DEL: return CMD_DEL;
                WORD_SET: return CMD_SET;
                default:  return CMD_BAD;
            endcase
        endfunction

        function void shift_word(input logic [7:0] c);
            word = {word[15:0], c};
            if (word_len < 3'd4) begin
                word_len++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function string show(input t_result r);
            return $sformatf(
                "byte %02h role %0d pos %0d done %0b status %0b cmd %0d klen %0d vlen %0d",
                r.echo_byte, r.role, r.field_pos, r.done_res, r.status, r.command,
                r.key_length, r.value_length);
        endfunction

        // predict the output transaction caused by one accepted input byte
        function void note_input(input logic [7:0] c, input logic last);
            t_result     r;
            t_cmd        code;
            logic [10:0] vl;
            bit          ok;
            bit          ws;
            r = '0;
            r.echo_byte = c;
            r.role = ROLE_NONE;
            ws = space_char(c);
            if (!stopped) begin
                if (c == CH_NUL) begin
                    stopped = 1'b1;
                end else begin
                    if (line_len < 11'(MAX_LINE)) begin
                        line_len++;
                    end
                    case (ph)
                        PH_LEAD: begin
                            if (!ws) begin
                                shift_word(c);
                                ph = PH_CMD;
                            end
                        end
                        PH_CMD: begin
                            if (!ws) begin
                                shift_word(c);
                            end else begin
                                ph = (word_cmd() == CMD_BAD) ? PH_ERR : PH_GAP1;
                            end
                        end
                        PH_GAP1: begin
                            if (!ws) begin
                                r.role = ROLE_KEY;
                                key_len = 9'd1;
                                ph = PH_KEY;
                            end
                        end
                        PH_KEY: begin
                            if (!ws) begin
                                r.role = ROLE_KEY;
                                r.field_pos = 10'(key_len);
                                if (key_len < 9'(KEY_BYTES)) begin
                                    key_len++;
                                end
                            end else begin
                                ph = (word_cmd() == CMD_SET) ? PH_GAP2 : PH_TAIL;
                            end
                        end
                        PH_TAIL: begin
                            if (!ws) begin
                                ph = PH_ERR;
                            end
                        end
                        PH_GAP2: begin
                            if (!ws) begin
                                r.role = ROLE_VALUE;
                                val_len = 11'd1;
                                crlf_len = '0;
                                ph = PH_VALUE;
                            end
                        end
                        PH_VALUE: begin
                            r.role = ROLE_VALUE;
                            r.field_pos = (val_len < 11'd1023) ? 10'(val_len) : 10'd1023;
                            if (val_len < 11'(MAX_LINE)) begin
                                val_len++;
                            end
                            if (c == CH_LF || c == CH_CR) begin
                                if (crlf_len < 11'(MAX_LINE)) begin
                                    crlf_len++;
                                end
                            end else begin
                                crlf_len = '0;
                            end
                        end
                        default: begin
                            ph = PH_ERR;
                        end
                    endcase
                end
            end

            if (last) begin
                code = word_cmd();
                vl = (val_len >= crlf_len) ? val_len - crlf_len : 11'd0;
                ok = 1'b0;
                if (line_len < 11'(MAX_LINE)) begin
                    if ((ph == PH_KEY || ph == PH_TAIL) &&
                        (code == CMD_GET || code == CMD_DEL)) begin
                        ok = key_len < 9'(KEY_BYTES);
                    end else if (ph == PH_VALUE && code == CMD_SET) begin
                        ok = (key_len < 9'(KEY_BYTES)) && (vl < 11'(VALUE_BYTES));
                    end
                end
                r.done_res = 1'b1;
                if (ok) begin
                    r.command = code;
                    r.key_length = (key_len > 9'd255) ? 8'd255 : 8'(key_len);
                    if (code == CMD_SET) begin
                        r.value_length = (vl > 11'd1023) ? 10'd1023 : 10'(vl);
                    end
                end else begin
                    r.status = 1'b1;
                end
                clear_line();
            end
            expected_q.push_back(r);
        endfunction

        // compare one output transaction with the oldest prediction
        function void check_result(input logic [39:0] data, input logic [1:0] user,
                                   input logic last);
            t_result a;
            t_result e;
            bit      bad;
            a.echo_byte    = data[7:0];
            a.role         = t_role'(user);
            a.field_pos    = data[17:8];
            a.done_res     = last;
            a.status       = data[18];
            a.command      = data[20:19];
            a.key_length   = data[28:21];
            a.value_length = data[38:29];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected output transaction: got %s", show(a));
                end
                return;
            end
            e = expected_q.pop_front();
            bad = (a.echo_byte !== e.echo_byte) || (a.role !== e.role) ||
                  (a.field_pos !== e.field_pos) || (a.done_res !== e.done_res) ||
                  (a.status !== e.status) || (a.command !== e.command) ||
                  (a.key_length !== e.key_length) || (a.value_length !== e.value_length);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected %s", show(e));
                    $display("          got      %s", show(a));
                end
            end
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives request lines byte by byte into the parser with random gaps and
// output stalls, and checks every output transaction against a predictor
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import kvp_pkg::*;
    import kvp_scoreboard_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    line_scoreboard sb = new();
    bit             no_idle = 1'b0;
    logic [7:0]     line_q[$];
    int             sent_bytes = 0;

    kv_request_line_parser dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser, m_tlast);
            end
        end
    end

    // output side back pressure
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            repeat (stall) begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 5))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (space_char(b));
        return b;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_q.push_back(s[i]);
        end
    endfunction

    function automatic void push_ws(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) line_q.push_back(blank_byte());
    endfunction

    function automatic void push_token(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) line_q.push_back(token_byte());
    endfunction

    // value region: n content bytes with inner whitespace, then a cr/lf run
    function automatic void push_value(input int n, input int crlf);
        line_q.push_back(token_byte());
        repeat (n - 1) begin
            line_q.push_back(($urandom_range(0, 3) == 0) ? blank_byte() : token_byte());
        end
        repeat (crlf) line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    endfunction

    function automatic void build_good(input bit with_value);
        int klen;
        klen = ($urandom_range(0, 149) == 0) ? $urandom_range(250, 256) : $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0) begin
            push_ws(1, 3);
        end
        push_text(with_value ? "SET" : ($urandom_range(0, 1) ? "GET" : "DEL"));
        push_ws(1, 3);
        push_token(klen, klen);
        if (with_value) begin
            push_ws(1, 3);
            push_value($urandom_range(1, 12), $urandom_range(0, 3));
        end else if ($urandom_range(0, 1)) begin
            push_ws(1, 3);
        end
    endfunction

    function automatic void build_broken();
        int idx;
        case ($urandom_range(0, 5))
            0: begin
                push_ws(0, 1);
                case ($urandom_range(0, 4))
                    0:       push_text("GETS");
                    1:       push_text("GE");
                    2:       push_text("get");
                    3:       push_text("SE");
                    default: push_token(1, 5);
                endcase
                push_ws(1, 2);
                push_token(1, 4);
            end
            1: begin
                push_text($urandom_range(0, 1) ? "SET" : ($urandom_range(0, 1) ? "GET" : "DEL"));
                push_ws(0, 3);
            end
            2: begin
                push_text("SET");
                push_ws(1, 2);
                push_token(1, 6);
                push_ws(0, 2);
            end
            3: begin
                push_text($urandom_range(0, 1) ? "GET" : "DEL");
                push_ws(1, 2);
                push_token(1, 5);
                push_ws(1, 2);
                push_token(1, 4);
                push_ws(0, 2);
            end
            4: begin
                push_ws(1, 5);
            end
            default: begin
                build_good($urandom_range(0, 1));
                idx = $urandom_range(0, line_q.size() - 1);
                line_q[idx] = $urandom_range(0, 1) ? blank_byte() : token_byte();
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_line();
        int n;
        n = line_q.size();
        for (int i = 0; i < n; i++) begin
            send_byte(line_q[i], i == n - 1);
        end
        sent_bytes += n;
        line_q.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        push_text("GET k");
        send_line();
        push_text("DEL abc \t");
        send_line();
        push_text("\t SET key value");
        send_line();
        push_text("SET k a b c");
        send_line();
        push_text("SET k v");
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        send_line();
        push_text("SET k v");
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        push_text("x");
        line_q.push_back(CH_CR);
        send_line();
        push_text("SET k ");
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        send_line();
        push_text("get k");
        send_line();
        push_text("GETX k");
        send_line();
        push_text("GET");
        send_line();
        push_text("GET ");
        send_line();
        push_text("GET k extra");
        send_line();
        push_text("SET key");
        send_line();
        push_text("GET k");
        line_q.push_back(CH_NUL);
        push_text("zz");
        send_line();
        line_q.push_back(CH_NUL);
        send_line();
        line_q.push_back(8'hFF);
        send_line();
        push_text("DEL ");
        line_q.push_back(8'hFF);
        line_q.push_back(8'h80);
        line_q.push_back(8'h7F);
        line_q.push_back(CH_LF);
        send_line();
        // key length limit
        push_text("DEL ");
        push_token(256, 256);
        send_line();
        // line length limit and position saturation
        push_text("SET k ");
        push_value(1034, 0);
        send_line();
        drain();

        // random lines
        while (sent_bytes < 1750) begin
            no_idle = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: build_good(1'b0);
                3, 4, 5: build_good(1'b1);
                6, 7: build_broken();
                8: begin
                    build_good($urandom_range(0, 1));
                    line_q.insert($urandom_range(0, line_q.size()), CH_NUL);
                    repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            send_line();
            if ($urandom_range(0, 24) == 0) begin
                drain();
            end
        end

        drain();
        repeat (5) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/kvp_pkg.sv
rtl/core/kvp_parse.sv
rtl/core/kv_request_line_parser.sv
tb/kvp_scoreboard_pkg.sv
tb/testbench.sv
